>>> sv/wrst_pkg.sv
// ---------------------------------------------------------------------------
// Weighted random select table package
// Sizes, result codes, controller states and the command and status
// structures shared by the controller, the datapath and the checker.
// ---------------------------------------------------------------------------
package wrst_pkg;

   // Table geometry.
   localparam int ENTRIES     = 64;
   localparam int WEIGHT_BITS = 16;

   // Field widths of the request and response words.
   localparam int ID_BITS     = 6;
   localparam int NEW_W_BITS  = 16;
   localparam int DRAW_BITS   = 22;
   localparam int STATUS_BITS = 2;
   localparam int TOTAL_OUT_BITS = 22;

   // Derived widths.
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);
   localparam int TOTAL_BITS = WEIGHT_BITS + $clog2(ENTRIES);
   localparam int EXT_BITS   = (ID_BITS > CNT_BITS) ? ID_BITS : CNT_BITS;
   localparam int WIDE_BITS  = (TOTAL_BITS > DRAW_BITS) ? TOTAL_BITS : DRAW_BITS;
   localparam int CMP_BITS   = (DRAW_BITS > WEIGHT_BITS) ? DRAW_BITS : WEIGHT_BITS;
   localparam int WIDE_OUT_BITS =
      (TOTAL_BITS > TOTAL_OUT_BITS) ? TOTAL_BITS : TOTAL_OUT_BITS;

   localparam logic [TOTAL_OUT_BITS-1:0] TOTAL_OUT_MAX = '1;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Request modes.
   localparam logic MODE_SET    = 1'b0;
   localparam logic MODE_CHOOSE = 1'b1;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET_RD,
      ST_SET_WR,
      ST_CHECK,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic set_write;
      logic walk_init;
      logic walk_step;
      logic res_empty;
      logic res_range;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_choose;
      logic req_id_ok;
      logic total_zero;
      logic draw_bad;
      logic hit;
      logic rsp_free;
   } sts_type;

   // Clamp the running total to the width of the response field.
   function automatic logic [TOTAL_OUT_BITS-1:0] sat_total(
      input logic [TOTAL_BITS-1:0] total
   );
      logic [WIDE_OUT_BITS-1:0] wide;
      wide = WIDE_OUT_BITS'(total);
      if (wide > WIDE_OUT_BITS'(TOTAL_OUT_MAX)) begin
         return TOTAL_OUT_MAX;
      end
      return TOTAL_OUT_BITS'(wide);
   endfunction

endpackage

>>> sv/wrst_ctrl.sv
// ---------------------------------------------------------------------------
// Weighted random select table controller
// Sequences set items, range checks and the entry walk of choose items, and
// hands finished results to the response register.
// ---------------------------------------------------------------------------
module wrst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wrst_pkg::sts_type sts,
   output wrst_pkg::cmd_type cmd
);

   wrst_pkg::state_type state_ff;
   wrst_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         wrst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (sts.req_choose) begin
                  state_in = wrst_pkg::ST_CHECK;
               end else if (sts.req_id_ok) begin
                  state_in = wrst_pkg::ST_SET_RD;
               end else begin
                  state_in = wrst_pkg::ST_FINISH;
               end
            end
         end
         wrst_pkg::ST_SET_RD: begin
            // The old weight is read out of the store in this cycle.
            state_in = wrst_pkg::ST_SET_WR;
         end
         wrst_pkg::ST_SET_WR: begin
            cmd.set_write = 1'b1;
            state_in      = wrst_pkg::ST_FINISH;
         end
         wrst_pkg::ST_CHECK: begin
            if (sts.total_zero) begin
               cmd.res_empty = 1'b1;
               state_in      = wrst_pkg::ST_FINISH;
            end else if (sts.draw_bad) begin
               cmd.res_range = 1'b1;
               state_in      = wrst_pkg::ST_FINISH;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = wrst_pkg::ST_WALK;
            end
         end
         wrst_pkg::ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.hit) begin
               state_in = wrst_pkg::ST_FINISH;
            end
         end
         wrst_pkg::ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = wrst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrst_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/wrst_datapath.sv
// ---------------------------------------------------------------------------
// Weighted random select table datapath
// Holds the weight store with per-entry valid bits, the running total, the
// walk counter and remainder, and the response register.
// ---------------------------------------------------------------------------
module wrst_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_mode,
   input  logic [wrst_pkg::ID_BITS-1:0]          req_entry_id,
   input  logic [wrst_pkg::NEW_W_BITS-1:0]       req_new_weight,
   input  logic [wrst_pkg::DRAW_BITS-1:0]        req_draw_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [wrst_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [wrst_pkg::ID_BITS-1:0]          rsp_chosen_id,
   output logic [wrst_pkg::TOTAL_OUT_BITS-1:0]   rsp_total_after,
   input  wrst_pkg::cmd_type                     cmd,
   output wrst_pkg::sts_type                     sts
);

   localparam int IB = wrst_pkg::IDX_BITS;
   localparam int WB = wrst_pkg::WEIGHT_BITS;
   localparam int TB = wrst_pkg::TOTAL_BITS;
   localparam int DB = wrst_pkg::DRAW_BITS;
   localparam int CB = wrst_pkg::CNT_BITS;

   // Weight store and its valid bits.
   logic [WB-1:0]                mem [wrst_pkg::ENTRIES];
   logic [wrst_pkg::ENTRIES-1:0] vld_ff;
   logic [WB-1:0]                rd_data_ff;
   logic                         rd_vld_ff;
   logic [IB-1:0]                rd_addr;
   logic [WB-1:0]                cur;

   // Latched request word.
   logic [IB-1:0] addr_ff;
   logic [WB-1:0] weight_ff;
   logic [DB-1:0] draw_ff;

   // Running total and walk state.
   logic [TB-1:0]       total_ff;
   logic [DB-1:0]       rest_ff;
   logic [CB-1:0]       idx_ff;
   logic                pend_vld_ff;
   logic [IB-1:0]       pend_idx_ff;
   logic                issue;

   // Result and response registers.
   wrst_pkg::status_type              res_status_ff;
   logic [wrst_pkg::ID_BITS-1:0]      res_id_ff;
   logic                              rsp_valid_ff;
   wrst_pkg::status_type              rsp_status_ff;
   logic [wrst_pkg::ID_BITS-1:0]      rsp_id_ff;
   logic [wrst_pkg::TOTAL_OUT_BITS-1:0] rsp_total_ff;

   // The walk reads its counter; otherwise the store is read at the set id.
   assign issue   = idx_ff < CB'(wrst_pkg::ENTRIES);
   assign rd_addr = cmd.walk_step ? idx_ff[IB-1:0] : addr_ff;
   assign cur     = rd_vld_ff ? rd_data_ff : '0;

   // Store read and write ports.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (cmd.set_write) begin
         mem[addr_ff] <= weight_ff;
      end
   end

   // Valid bits: an entry never written reads as weight zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[rd_addr];
         if (cmd.set_write) begin
            vld_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         addr_ff   <= IB'(req_entry_id);
         weight_ff <= WB'(req_new_weight);
         draw_ff   <= req_draw_value;
      end
   end

   // Running total: subtract the old weight, add the new one.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (cmd.set_write) begin
         total_ff <= total_ff - TB'(cur) + TB'(weight_ff);
      end
   end

   // Entry walk: one read issued and one pending entry examined per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         idx_ff      <= '0;
      end else if (cmd.walk_init) begin
         pend_vld_ff <= 1'b0;
         idx_ff      <= '0;
      end else if (cmd.walk_step) begin
         pend_vld_ff <= issue;
         if (issue) begin
            idx_ff <= idx_ff + CB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         rest_ff <= draw_ff;
      end else if (cmd.walk_step) begin
         pend_idx_ff <= idx_ff[IB-1:0];
         if (pend_vld_ff && !sts.hit) begin
            rest_ff <= rest_ff - DB'(cur);
         end
      end
   end

   // Result fields of the item in progress.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         res_status_ff <= wrst_pkg::STATUS_OK;
         res_id_ff     <= '0;
      end else if (cmd.res_empty) begin
         res_status_ff <= wrst_pkg::STATUS_EMPTY;
      end else if (cmd.res_range) begin
         res_status_ff <= wrst_pkg::STATUS_RANGE;
      end else if (cmd.walk_step && sts.hit) begin
         res_id_ff <= wrst_pkg::ID_BITS'(pend_idx_ff);
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_total_ff  <= wrst_pkg::sat_total(total_ff);
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.req_choose = (req_mode == wrst_pkg::MODE_CHOOSE);
      sts.req_id_ok  = wrst_pkg::EXT_BITS'(req_entry_id) <
                       wrst_pkg::EXT_BITS'(wrst_pkg::ENTRIES);
      sts.total_zero = (total_ff == '0);
      sts.draw_bad   = (draw_ff == '0) ||
                       (wrst_pkg::WIDE_BITS'(draw_ff) > wrst_pkg::WIDE_BITS'(total_ff));
      sts.hit        = pend_vld_ff &&
                       (wrst_pkg::CMP_BITS'(rest_ff) <= wrst_pkg::CMP_BITS'(cur));
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_id   = rsp_id_ff;
   assign rsp_total_after = rsp_total_ff;

endmodule

>>> sv/weighted_random_select_table.sv
// A set item reads the old weight, then writes the new one into the store and the
// total. A choose item skips the walk when the table is empty or the draw is out
// of range; otherwise the walk reads one stored weight per cycle.
// Throughput: one item at a time; the next word is taken once the result sits
// in the response register. Reset is synchronous and clears the table at once.
// ---------------------------------------------------------------------------
// Weighted random select table
// Roulette wheel selection over a table of weights with a running total.
// ---------------------------------------------------------------------------
module weighted_random_select_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [wrst_pkg::ID_BITS-1:0]        req_entry_id,
   input  logic [wrst_pkg::NEW_W_BITS-1:0]     req_new_weight,
   input  logic [wrst_pkg::DRAW_BITS-1:0]      req_draw_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wrst_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [wrst_pkg::ID_BITS-1:0]        rsp_chosen_id,
   output logic [wrst_pkg::TOTAL_OUT_BITS-1:0] rsp_total_after
);

   wrst_pkg::cmd_type cmd;
   wrst_pkg::sts_type sts;

   // Sequencer.
   wrst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store, total and walk datapath.
   wrst_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_mode        (req_mode),
      .req_entry_id    (req_entry_id),
      .req_new_weight  (req_new_weight),
      .req_draw_value  (req_draw_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_chosen_id   (rsp_chosen_id),
      .rsp_total_after (rsp_total_after),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule

>>> sv/wrst_checker.sv
// ---------------------------------------------------------------------------
// Weighted random select table checker
// Port-level assertions on the request and response words, bound to the top.
// ---------------------------------------------------------------------------
module wrst_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [wrst_pkg::STATUS_BITS-1:0]    rsp_status,
   input logic [wrst_pkg::ID_BITS-1:0]        rsp_chosen_id,
   input logic [wrst_pkg::TOTAL_OUT_BITS-1:0] rsp_total_after
);

   // Only one item is in flight: acceptance drops ready for the next cycle.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready stayed high after an accepted word");

   // A failed choose reports no entry.
   a_fail_no_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != wrst_pkg::STATUS_OK) |-> (rsp_chosen_id == '0))
      else $error("chosen id is nonzero on an error response");

   // An empty-table answer goes with a zero total.
   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == wrst_pkg::STATUS_EMPTY) |-> (rsp_total_after == '0))
      else $error("empty status with nonzero total");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_chosen_id) &&
          $stable(rsp_total_after)))
      else $error("stalled response word changed");

endmodule

bind weighted_random_select_table wrst_checker u_wrst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_chosen_id   (rsp_chosen_id),
   .rsp_total_after (rsp_total_after)
);

>>> verif/weighted_random_select_table_tb.sv
// ---------------------------------------------------------------------------
// Weighted random select table testbench
// Drives set and choose words into the roulette wheel table and checks every
// response word against the script's typed answer or else a local model of the
// weights and the running total. A directed script covers the empty table,
// range errors and the field extremes, then random phases with sender gaps,
// receiver stalls and a long receiver hold-off exercise the handshakes.
// ---------------------------------------------------------------------------
module weighted_random_select_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wrst_pkg::*;

   localparam int  CLK_HALF     = 5;
   localparam int  CYCLE_LIMIT  = 1000000;
   localparam int  HOLD_CYCLES  = 400;
   localparam int  PHASE_WORDS  = 210;
   localparam int  SCRIPT_ROWS  = 25;
   localparam logic [DRAW_BITS-1:0] DRAW_MAX = '1;

   typedef struct packed {
      status_type                 status;
      logic [ID_BITS-1:0]         chosen_id;
      logic [TOTAL_OUT_BITS-1:0]  total_after;
   } pick_result_type;

   typedef struct packed {
      logic                       mode;
      logic [ID_BITS-1:0]         entry_id;
      logic [NEW_W_BITS-1:0]      new_weight;
      logic [DRAW_BITS-1:0]       draw_value;
      bit                         typed;
      pick_result_type            res;
   } script_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_mode = MODE_SET;
   logic [ID_BITS-1:0]           req_entry_id = '0;
   logic [NEW_W_BITS-1:0]        req_new_weight = '0;
   logic [DRAW_BITS-1:0]         req_draw_value = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0]       rsp_status;
   logic [ID_BITS-1:0]           rsp_chosen_id;
   logic [TOTAL_OUT_BITS-1:0]    rsp_total_after;

   // Local copy of the table and the running total.
   logic [WEIGHT_BITS-1:0]       weight_tbl [ENTRIES];
   logic [31:0]                  weight_sum;

   // Response words still owed by the block, oldest first.
   pick_result_type              awaited_words [$];

   // Typed answer for the word on the request port, if the script gives one.
   bit                           cur_typed = 1'b0;
   pick_result_type              cur_answer;

   int                           errors = 0;
   int                           cycles = 0;
   int                           set_words = 0;
   int                           choose_words = 0;
   int                           ok_picks = 0;
   int                           empty_picks = 0;
   int                           range_picks = 0;
   int                           stall_pct = 0;
   int                           hold_left = 0;
   bit                           hold_go = 1'b0;

   script_row_type script [SCRIPT_ROWS] = '{
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd5,     1'b1, '{STATUS_EMPTY, 6'd0,  22'd0}},
      '{MODE_SET,    6'd0,  16'hFFFF, DRAW_MAX,  1'b1, '{STATUS_OK,    6'd0,  22'd65535}},
      '{MODE_SET,    6'd63, 16'h0001, 22'd0,     1'b1, '{STATUS_OK,    6'd0,  22'd65536}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd0,     1'b1, '{STATUS_RANGE, 6'd0,  22'd65536}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd65537, 1'b1, '{STATUS_RANGE, 6'd0,  22'd65536}},
      '{MODE_CHOOSE, 6'd63, 16'hFFFF, DRAW_MAX,  1'b1, '{STATUS_RANGE, 6'd0,  22'd65536}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd1,     1'b1, '{STATUS_OK,    6'd0,  22'd65536}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd65535, 1'b1, '{STATUS_OK,    6'd0,  22'd65536}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd65536, 1'b1, '{STATUS_OK,    6'd63, 22'd65536}},
      '{MODE_SET,    6'd0,  16'h0000, 22'd0,     1'b1, '{STATUS_OK,    6'd0,  22'd1}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd1,     1'b1, '{STATUS_OK,    6'd63, 22'd1}},
      '{MODE_SET,    6'd63, 16'h0000, 22'd0,     1'b1, '{STATUS_OK,    6'd0,  22'd0}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd1,     1'b1, '{STATUS_EMPTY, 6'd0,  22'd0}},
      '{MODE_SET,    6'd21, 16'h5555, 22'd0,     1'b0, '{STATUS_OK,    6'd0,  22'd0}},
      '{MODE_SET,    6'd42, 16'hAAAA, 22'd0,     1'b0, '{STATUS_OK,    6'd0,  22'd0}},
      '{MODE_SET,    6'd32, 16'h8000, 22'd0,     1'b0, '{STATUS_OK,    6'd0,  22'd0}},
      '{MODE_SET,    6'd1,  16'h0001, 22'd0,     1'b0, '{STATUS_OK,    6'd0,  22'd0}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd1,     1'b0, '{STATUS_OK,    6'd0,  22'd0}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'd2,     1'b0, '{STATUS_OK,    6'd0,  22'd0}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'h005557, 1'b0, '{STATUS_OK,   6'd0,  22'd0}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'h018000, 1'b0, '{STATUS_OK,   6'd0,  22'd0}},
      '{MODE_SET,    6'd42, 16'h0001, 22'd0,     1'b0, '{STATUS_OK,    6'd0,  22'd0}},
      '{MODE_CHOOSE, 6'd0,  16'h0000, 22'h018000, 1'b0, '{STATUS_OK,   6'd0,  22'd0}},
      '{MODE_SET,    6'd63, 16'hFFFF, 22'h2AAAAA, 1'b0, '{STATUS_OK,   6'd0,  22'd0}},
      '{MODE_CHOOSE, 6'd42, 16'h5555, 22'h015555, 1'b0, '{STATUS_OK,   6'd0,  22'd0}}
   };

   weighted_random_select_table dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_entry_id    (req_entry_id),
      .req_new_weight  (req_new_weight),
      .req_draw_value  (req_draw_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_chosen_id   (rsp_chosen_id),
      .rsp_total_after (rsp_total_after)
   );

   always #CLK_HALF clock = ~clock;

   // Apply one word to the local table and return the response it earns.
   function automatic pick_result_type roulette_predict(
      input logic                  mode,
      input logic [ID_BITS-1:0]    entry_id,
      input logic [NEW_W_BITS-1:0] new_weight,
      input logic [DRAW_BITS-1:0]  draw_value
   );
      pick_result_type r;
      logic [31:0]     rest;
      bit              found;
      r.status    = STATUS_OK;
      r.chosen_id = '0;
      if (mode == MODE_SET) begin
         if (int'(entry_id) < ENTRIES) begin
            weight_sum = weight_sum - 32'(weight_tbl[entry_id]);
            weight_tbl[entry_id] = WEIGHT_BITS'(new_weight);
            weight_sum = weight_sum + 32'(weight_tbl[entry_id]);
         end
      end else if (weight_sum == 0) begin
         r.status = STATUS_EMPTY;
      end else if (draw_value == 0 || 32'(draw_value) > weight_sum) begin
         r.status = STATUS_RANGE;
      end else begin
         // Walk the wheel in ascending id, skipping absent entries.
         rest  = 32'(draw_value);
         found = 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!found && weight_tbl[i] != 0) begin
               if (rest <= 32'(weight_tbl[i])) begin
                  r.chosen_id = ID_BITS'(i);
                  found       = 1'b1;
               end else begin
                  rest = rest - 32'(weight_tbl[i]);
               end
            end
         end
      end
      r.total_after = (weight_sum > 32'(DRAW_MAX)) ? TOTAL_OUT_MAX
                                                   : TOTAL_OUT_BITS'(weight_sum);
      return r;
   endfunction

   // Accepted words on both ports: predict on the request side, check on the
   // response side. The response is checked first, since it belongs to an
   // older request.
   always @(posedge clock) begin : word_monitor
      pick_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_words.size() == 0) begin
               errors++;
               $display("%0t: response word with none expected: status %0d id %0d total %0d",
                        $time, rsp_status, rsp_chosen_id, rsp_total_after);
            end else begin
               want = awaited_words.pop_front();
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_chosen_id !== want.chosen_id) begin
                  errors++;
                  $display("%0t: chosen_id mismatch: expected %0d, actual %0d",
                           $time, want.chosen_id, rsp_chosen_id);
               end
               if (rsp_total_after !== want.total_after) begin
                  errors++;
                  $display("%0t: total_after mismatch: expected %0d, actual %0d",
                           $time, want.total_after, rsp_total_after);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = roulette_predict(req_mode, req_entry_id, req_new_weight,
                                    req_draw_value);
            if (cur_typed) begin
               want = cur_answer;
            end
            awaited_words = {awaited_words, want};
            if (req_mode == MODE_SET) begin
               set_words++;
            end else begin
               choose_words++;
               case (want.status)
                  STATUS_OK:    ok_picks++;
                  STATUS_EMPTY: empty_picks++;
                  default:      range_picks++;
               endcase
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_go) begin
         hold_left = HOLD_CYCLES;
         hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d words outstanding",
                  $time, cycles, awaited_words.size());
         $display("weighted_random_select_table_tb: FAIL");
         $finish;
      end
   end

   // Offer one word, with random idle cycles ahead of it, and return at the
   // edge that accepts it.
   task automatic send_word(
      input logic                  mode,
      input logic [ID_BITS-1:0]    entry_id,
      input logic [NEW_W_BITS-1:0] new_weight,
      input logic [DRAW_BITS-1:0]  draw_value,
      input bit                    typed,
      input pick_result_type       answer,
      input int                    idle_pct
   );
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_mode       <= mode;
      req_entry_id   <= entry_id;
      req_new_weight <= new_weight;
      req_draw_value <= draw_value;
      req_valid      <= 1'b1;
      cur_typed      = typed;
      cur_answer     = answer;
      do begin
         @(posedge clock);
      end while (!(req_valid && req_ready));
   endtask

   // Sender pause until every owed response word has come back.
   task automatic drain_words();
      @(negedge clock);
      req_valid <= 1'b0;
      cur_typed = 1'b0;
      while (awaited_words.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin : stimulus
      int                    send_idle;
      int                    id_top;
      logic                  mode;
      logic [ID_BITS-1:0]    entry_id;
      logic [NEW_W_BITS-1:0] new_weight;
      logic [DRAW_BITS-1:0]  draw_value;
      int                    pick;
      pick_result_type       blank;

      blank = '{STATUS_OK, '0, '0};
      for (int i = 0; i < ENTRIES; i++) begin
         weight_tbl[i] = '0;
      end
      weight_sum = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed script: empty table, range errors, extremes, ignored fields.
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         send_word(script[r].mode, script[r].entry_id, script[r].new_weight,
                   script[r].draw_value, script[r].typed, script[r].res, 0);
      end
      drain_words();

      // Random phases: idle mix and the range of ids in play.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle = 0;  stall_pct = 0;  id_top = 63; end
            1: begin send_idle = 55; stall_pct = 0;  id_top = 63; end
            2: begin send_idle = 0;  stall_pct = 55; id_top = 63; end
            3: begin send_idle = 29; stall_pct = 29; id_top = 3;  end
            default: begin send_idle = 29; stall_pct = 29; id_top = 63; end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Long receiver hold-off while the sender keeps offering words.
            if (phase == 0 && n == PHASE_WORDS / 2) begin
               hold_go = 1'b1;
            end
            mode       = ($urandom_range(99) < 50) ? MODE_SET : MODE_CHOOSE;
            entry_id   = ID_BITS'($urandom_range(id_top));
            new_weight = NEW_W_BITS'($urandom);
            draw_value = DRAW_BITS'($urandom);
            pick       = $urandom_range(99);
            if (mode == MODE_SET) begin
               if (pick < 15) begin
                  new_weight = '0;
               end else if (pick < 25) begin
                  new_weight = '1;
               end else if (pick < 35) begin
                  new_weight = NEW_W_BITS'($urandom_range(15, 1));
               end
            end else if (weight_sum != 0) begin
               // Mostly legal draws, some zero, some past the total.
               if (pick < 70) begin
                  draw_value = DRAW_BITS'($urandom_range(weight_sum, 1));
               end else if (pick < 80) begin
                  draw_value = '0;
               end else if (pick < 90 && weight_sum < 32'(DRAW_MAX)) begin
                  draw_value = DRAW_BITS'($urandom_range(32'(DRAW_MAX), weight_sum + 1));
               end
            end
            send_word(mode, entry_id, new_weight, draw_value, 1'b0, blank, send_idle);
         end
         drain_words();
      end

      // Let any stray response word show up before judging.
      repeat (ENTRIES + 8) @(posedge clock);

      $display("Covered %0d set words and %0d choose words in %0d cycles.",
               set_words, choose_words, cycles);
      $display("Choose outcomes: %0d picked, %0d on an empty table, %0d draws out of range.",
               ok_picks, empty_picks, range_picks);
      if (errors == 0 && awaited_words.size() == 0) begin
         $display("weighted_random_select_table_tb: PASS");
      end else begin
         $display("weighted_random_select_table_tb: FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/wrst_pkg.sv
sv/wrst_ctrl.sv
sv/wrst_datapath.sv
sv/weighted_random_select_table.sv
sv/wrst_checker.sv
verif/weighted_random_select_table_tb.sv
